// ===== sv/sequence_location_hash_cache_unit_defines.svh =====
// Assertion macros for the sequence location hash cache.
// Used by the port checker; depends on nothing else.
`ifndef SEQUENCE_LOCATION_HASH_CACHE_UNIT_DEFINES_SVH
`define SEQUENCE_LOCATION_HASH_CACHE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// ===== sv/slhc_pkg.sv =====
// Shared types and codes for the sequence location hash cache.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package slhc_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_ACCESS
   } state_type;

   typedef struct packed {
      logic hit;
      logic has_free;
   } match_flags_type;

endpackage

// ===== sv/slhc_bucket_match.sv =====
// Compares one key against all ways of a bucket row and finds the lowest free way.
// Depends on slhc_pkg.
`timescale 1ns / 1ps

module slhc_bucket_match #(
   parameter int WAYS     = 4,
   parameter int WAY_BITS = 2
) (
   input  logic [WAYS-1:0]                  row_valid,
   input  logic [WAYS*slhc_pkg::KEY_W-1:0]  row_keys,
   input  logic [slhc_pkg::KEY_W-1:0]       key,
   output slhc_pkg::match_flags_type        flags,
   output logic [WAY_BITS-1:0]              hit_way,
   output logic [WAY_BITS-1:0]              free_way
);

   always_comb begin
      flags    = '0;
      hit_way  = '0;
      free_way = '0;
      // Walk from the top way down so that the lowest way wins.
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_valid[w] && row_keys[w*slhc_pkg::KEY_W +: slhc_pkg::KEY_W] == key) begin
            flags.hit = 1'b1;
            hit_way   = WAY_BITS'(w);
         end
         if (!row_valid[w]) begin
            flags.has_free = 1'b1;
            free_way       = WAY_BITS'(w);
         end
      end
   end

endmodule

// ===== sv/sequence_location_hash_cache_unit.sv =====
// Top level of the sequence location hash cache: bucket memory, control and result port.
// Depends on slhc_pkg and slhc_bucket_match.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Its result is driven on the
// rsp_ ports for exactly one cycle, marked by rsp_valid, from the rsp_ registers that
// are loaded when the access state ends; the receiver cannot stall it.
// Each request is handled in two steps: the bucket row is read from synchronous memory
// when it is taken, then the access state compares all ways and writes the row back, so
// busy is high in the cycle after each acceptance and no new request is taken until the
// access state is over. After reset a clearing pass walks all 2**BUCKET_BITS buckets and
// resets the valid bits, one bucket per cycle, with busy high.
module sequence_location_hash_cache_unit #(
   parameter int BUCKET_BITS = 8,
   parameter int WAYS        = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [slhc_pkg::OP_W-1:0]          req_operation,
   input  logic [slhc_pkg::KEY_W-1:0]         req_key,
   input  logic [slhc_pkg::VALUE_W-1:0]       req_new_value,
   output logic                               rsp_valid,
   output logic [slhc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [slhc_pkg::VALUE_W-1:0]       rsp_found_value
);

   localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int KEY_W       = slhc_pkg::KEY_W;
   localparam int VALUE_W     = slhc_pkg::VALUE_W;

   // Bucket memory: one row per bucket, all ways side by side.
   logic [WAYS-1:0]         valid_mem [NUM_BUCKETS];
   logic [WAYS*KEY_W-1:0]   key_mem   [NUM_BUCKETS];
   logic [WAYS*VALUE_W-1:0] value_mem [NUM_BUCKETS];

   slhc_pkg::state_type state_ff, state_in;
   logic [BUCKET_BITS-1:0] clear_addr_ff, clear_addr_in;

   logic [slhc_pkg::OP_W-1:0] op_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [VALUE_W-1:0]        new_value_ff;

   logic [WAYS-1:0]         rd_valid_ff;
   logic [WAYS*KEY_W-1:0]   rd_key_ff;
   logic [WAYS*VALUE_W-1:0] rd_value_ff;

   logic                            accept;
   logic                            wr_en;
   logic [BUCKET_BITS-1:0]          wr_addr;
   logic [WAYS-1:0]                 wr_valid_row;
   logic [WAYS*KEY_W-1:0]           wr_key_row;
   logic [WAYS*VALUE_W-1:0]         wr_value_row;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [slhc_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]              rsp_found_value_ff, rsp_found_value_in;

   slhc_pkg::match_flags_type flags;
   logic [WAY_BITS-1:0]       hit_way;
   logic [WAY_BITS-1:0]       free_way;

   slhc_bucket_match #(
      .WAYS     (WAYS),
      .WAY_BITS (WAY_BITS)
   ) u_match (
      .row_valid (rd_valid_ff),
      .row_keys  (rd_key_ff),
      .key       (key_ff),
      .flags     (flags),
      .hit_way   (hit_way),
      .free_way  (free_way)
   );

   assign busy   = (state_ff != slhc_pkg::STATE_IDLE);
   assign accept = start && (state_ff == slhc_pkg::STATE_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slhc_pkg::STATE_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_operation;
         key_ff       <= req_key;
         new_value_ff <= req_new_value;
      end
      rsp_status_ff      <= rsp_status_in;
      rsp_found_value_ff <= rsp_found_value_in;
   end

   // The bucket row is read when a request is taken and written back, if it changes, in the
   // next cycle; busy keeps the next read behind that write.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_valid_ff <= valid_mem[req_key[BUCKET_BITS-1:0]];
         rd_key_ff   <= key_mem[req_key[BUCKET_BITS-1:0]];
         rd_value_ff <= value_mem[req_key[BUCKET_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         valid_mem[wr_addr] <= wr_valid_row;
         key_mem[wr_addr]   <= wr_key_row;
         value_mem[wr_addr] <= wr_value_row;
      end
   end

   always_comb begin
      state_in           = state_ff;
      clear_addr_in      = clear_addr_ff;
      wr_en              = 1'b0;
      wr_addr            = key_ff[BUCKET_BITS-1:0];
      wr_valid_row       = rd_valid_ff;
      wr_key_row         = rd_key_ff;
      wr_value_row       = rd_value_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = slhc_pkg::ST_DONE;
      rsp_found_value_in = '0;

      unique case (state_ff)
         slhc_pkg::STATE_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_valid_row  = '0;
            wr_key_row    = '0;
            wr_value_row  = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (&clear_addr_ff) begin
               state_in = slhc_pkg::STATE_IDLE;
            end
         end
         slhc_pkg::STATE_IDLE: begin
            if (accept) begin
               state_in = slhc_pkg::STATE_ACCESS;
            end
         end
         slhc_pkg::STATE_ACCESS: begin
            state_in     = slhc_pkg::STATE_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               slhc_pkg::OP_LOOKUP: begin
                  if (flags.hit) begin
                     rsp_found_value_in = rd_value_ff[hit_way*VALUE_W +: VALUE_W];
                  end else begin
                     rsp_status_in = slhc_pkg::ST_NOT_FOUND;
                  end
               end
               slhc_pkg::OP_INSERT: begin
                  if (flags.hit) begin
                     rsp_status_in = slhc_pkg::ST_PRESENT;
                  end else if (!flags.has_free) begin
                     rsp_status_in = slhc_pkg::ST_FULL;
                  end else begin
                     wr_en                                   = 1'b1;
                     wr_valid_row[free_way]                  = 1'b1;
                     wr_key_row[free_way*KEY_W +: KEY_W]       = key_ff;
                     wr_value_row[free_way*VALUE_W +: VALUE_W] = new_value_ff;
                  end
               end
               slhc_pkg::OP_DELETE: begin
                  if (flags.hit) begin
                     wr_en                 = 1'b1;
                     wr_valid_row[hit_way] = 1'b0;
                  end else begin
                     rsp_status_in = slhc_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  // An unused operation code leaves the table alone and reports done.
               end
            endcase
         end
         default: begin
            state_in = slhc_pkg::STATE_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_value_ff;

endmodule

// ===== sv/slhc_checker.sv =====
// Port checker for the sequence location hash cache, bound to the top level.
// Depends on slhc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sequence_location_hash_cache_unit_defines.svh"

module slhc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [slhc_pkg::STATUS_W-1:0] rsp_status,
   input logic [slhc_pkg::VALUE_W-1:0]  rsp_found_value
);

   // A taken request holds the block busy for the following cycle.
   `SLHC_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // Every taken request gets its result, marked by rsp_valid.
   `SLHC_ASSERT_SAME(a_result_latency, clock, reset, start && !busy, ##2 rsp_valid)
   // Results never come in consecutive cycles.
   `SLHC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // A result with any status but done must carry a zero value.
   `SLHC_ASSERT_SAME(a_value_only_on_hit, clock, reset,
      rsp_valid && rsp_status != slhc_pkg::ST_DONE, rsp_found_value == '0)

endmodule

bind sequence_location_hash_cache_unit slhc_checker u_checker (.*);

// ===== tb/tb_sequence_location_hash_cache_unit.sv =====
// Self-checking testbench for the sequence location hash cache: lookups, inserts and deletes
// against an in-bench copy of the table, with random gaps between requests.
// Depends on slhc_pkg and the sequence_location_hash_cache_unit RTL.
`timescale 1ns / 1ps

module tb_sequence_location_hash_cache_unit;

   localparam int BUCKET_BITS = 8;
   localparam int WAYS        = 4;
   localparam int ENTRIES     = (1 << BUCKET_BITS) * WAYS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 850;
   localparam int HOT_BUCKETS = 8;
   localparam int HOT_KEYS    = 40;

   // The operation code that the block does not use.
   localparam logic [slhc_pkg::OP_W-1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic [slhc_pkg::STATUS_W-1:0] status;
      logic [slhc_pkg::VALUE_W-1:0]  found_value;
   } cache_reply_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [slhc_pkg::OP_W-1:0]     req_operation = '0;
   logic [slhc_pkg::KEY_W-1:0]    req_key = '0;
   logic [slhc_pkg::VALUE_W-1:0]  req_new_value = '0;
   logic                          rsp_valid;
   logic [slhc_pkg::STATUS_W-1:0] rsp_status;
   logic [slhc_pkg::VALUE_W-1:0]  rsp_found_value;

   // Shadow copy of the table, updated in request order.
   bit                           table_valid [ENTRIES];
   logic [slhc_pkg::KEY_W-1:0]   table_key   [ENTRIES];
   logic [slhc_pkg::VALUE_W-1:0] table_value [ENTRIES];

   cache_reply_type reply_queue[$];
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int status_count [4];
   int lookup_hits = 0;

   logic [slhc_pkg::KEY_W-1:0] hot_key [HOT_KEYS];

   sequence_location_hash_cache_unit #(
      .BUCKET_BITS(BUCKET_BITS),
      .WAYS(WAYS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_key(req_key),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d results outstanding", $time, reply_queue.size());
      $display("sequence_location_hash_cache_unit: mismatch");
      $finish;
   end

   // Computes the reply for one request and applies it to the shadow table.
   task automatic predict_reply(input logic [slhc_pkg::OP_W-1:0] op,
                                input logic [slhc_pkg::KEY_W-1:0] key,
                                input logic [slhc_pkg::VALUE_W-1:0] value,
                                output cache_reply_type reply);
      int base;
      int hit_way;
      int free_slot;
      base = int'(key[BUCKET_BITS-1:0]) * WAYS;
      hit_way = -1;
      free_slot = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_way < 0 && table_valid[base+w] && table_key[base+w] == key) hit_way = w;
         if (free_slot < 0 && !table_valid[base+w]) free_slot = w;
      end
      reply.status = slhc_pkg::ST_DONE;
      reply.found_value = '0;
      case (op)
         slhc_pkg::OP_LOOKUP: begin
            if (hit_way >= 0) begin
               reply.found_value = table_value[base+hit_way];
               lookup_hits++;
            end else begin
               reply.status = slhc_pkg::ST_NOT_FOUND;
            end
         end
         slhc_pkg::OP_INSERT: begin
            if (hit_way >= 0) begin
               reply.status = slhc_pkg::ST_PRESENT;
            end else if (free_slot < 0) begin
               reply.status = slhc_pkg::ST_FULL;
            end else begin
               table_valid[base+free_slot] = 1'b1;
               table_key[base+free_slot] = key;
               table_value[base+free_slot] = value;
            end
         end
         slhc_pkg::OP_DELETE: begin
            if (hit_way >= 0) table_valid[base+hit_way] = 1'b0;
            else reply.status = slhc_pkg::ST_NOT_FOUND;
         end
         default: begin
            // The spare operation code leaves the table alone.
         end
      endcase
      status_count[reply.status]++;
   endtask

   // Presents one request and returns at the edge that accepts it, with start still high.
   task automatic send_request(input logic [slhc_pkg::OP_W-1:0] op,
                               input logic [slhc_pkg::KEY_W-1:0] key,
                               input logic [slhc_pkg::VALUE_W-1:0] value);
      cache_reply_type reply;
      start <= 1'b1;
      req_operation <= op;
      req_key <= key;
      req_new_value <= value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_reply(op, key, value, reply);
      reply_queue.push_back(reply);
      sent_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   task automatic idle_gap(input bit enable);
      int roll;
      int cycles;
      cycles = 0;
      if (enable) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) cycles = 0;
         else if (roll < 90) cycles = $urandom_range(1, 3);
         else cycles = $urandom_range(8, 40);
      end
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [slhc_pkg::KEY_W-1:0] key_in_bucket(input int bucket);
      logic [slhc_pkg::KEY_W-1:0] key;
      key = {$urandom, $urandom};
      key[BUCKET_BITS-1:0] = bucket[BUCKET_BITS-1:0];
      return key;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (reply_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d value %h",
                     $time, rsp_status, rsp_found_value);
            error_count++;
         end else begin
            cache_reply_type want;
            want = reply_queue.pop_front();
            checked_count++;
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_value !== want.found_value) begin
               $display("%0t: found_value expected %h actual %h", $time, want.found_value,
                        rsp_found_value);
               error_count++;
            end
         end
      end else if (!reset && rsp_valid !== 1'b0) begin
         $display("%0t: rsp_valid expected 0 actual %b", $time, rsp_valid);
         error_count++;
      end
   end

   task automatic test_empty_lookup();
      send_request(slhc_pkg::OP_LOOKUP, '0, '0);
      send_request(slhc_pkg::OP_LOOKUP, '1, '1);
      send_request(slhc_pkg::OP_DELETE, '0, '0);
   endtask

   task automatic test_insert_lookup();
      send_request(slhc_pkg::OP_INSERT, '0, '0);
      send_request(slhc_pkg::OP_INSERT, '1, '1);
      send_request(slhc_pkg::OP_LOOKUP, '0, '1);
      send_request(slhc_pkg::OP_LOOKUP, '1, '0);
      send_request(slhc_pkg::OP_INSERT, '0, 32'h1234_5678);
      send_request(slhc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, '0);
   endtask

   task automatic test_bucket_full();
      logic [slhc_pkg::KEY_W-1:0] keys [WAYS+1];
      for (int i = 0; i <= WAYS; i++) keys[i] = key_in_bucket(5);
      for (int i = 0; i <= WAYS; i++) send_request(slhc_pkg::OP_INSERT, keys[i], $urandom);
      for (int i = 0; i <= WAYS; i++) send_request(slhc_pkg::OP_LOOKUP, keys[i], '0);
      // Freeing one way lets the refused key in.
      send_request(slhc_pkg::OP_DELETE, keys[1], '0);
      send_request(slhc_pkg::OP_DELETE, keys[1], '0);
      send_request(slhc_pkg::OP_INSERT, keys[WAYS], 32'hA5A5_5A5A);
      send_request(slhc_pkg::OP_LOOKUP, keys[WAYS], '0);
      send_request(slhc_pkg::OP_LOOKUP, keys[1], '0);
   endtask

   task automatic test_unused_op();
      send_request(OP_SPARE, '0, '1);
      send_request(OP_SPARE, '1, '0);
      send_request(slhc_pkg::OP_LOOKUP, '0, '0);
   endtask

   task automatic test_random_mix();
      int hot_bucket [HOT_BUCKETS];
      int roll;
      logic [slhc_pkg::OP_W-1:0] op;
      logic [slhc_pkg::KEY_W-1:0] key;
      logic [slhc_pkg::VALUE_W-1:0] value;
      bit gaps_on;
      for (int phase = 0; phase < 4; phase++) begin
         // A few busy buckets, each with more keys than ways, so hits and fulls are common.
         for (int b = 0; b < HOT_BUCKETS; b++) begin
            hot_bucket[b] = $urandom_range(0, (1 << BUCKET_BITS) - 1);
         end
         for (int k = 0; k < HOT_KEYS; k++) begin
            hot_key[k] = key_in_bucket(hot_bucket[k % HOT_BUCKETS]);
         end
         gaps_on = (phase != 2);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 36) op = slhc_pkg::OP_LOOKUP;
            else if (roll < 72) op = slhc_pkg::OP_INSERT;
            else if (roll < 95) op = slhc_pkg::OP_DELETE;
            else op = OP_SPARE;
            if ($urandom_range(0, 99) < 80) key = hot_key[$urandom_range(0, HOT_KEYS-1)];
            else key = {$urandom, $urandom};
            roll = $urandom_range(0, 19);
            value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
            send_request(op, key, value);
            idle_gap(gaps_on);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_lookup();
      test_insert_lookup();
      test_bucket_full();
      test_unused_op();
      idle_gap(1'b1);
      test_random_mix();
      start <= 1'b0;
      @(posedge clock);
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d requests and checked %0d results (%0d lookup hits).",
               sent_count, checked_count, lookup_hits);
      $display("Status mix: done %0d, not found %0d, present %0d, full %0d.",
               status_count[slhc_pkg::ST_DONE], status_count[slhc_pkg::ST_NOT_FOUND],
               status_count[slhc_pkg::ST_PRESENT], status_count[slhc_pkg::ST_FULL]);
      if (error_count == 0) begin
         $display("sequence_location_hash_cache_unit: match");
      end else begin
         $display("sequence_location_hash_cache_unit: mismatch");
      end
      $finish;
   end

endmodule
